>>> rtl/mcppwm_pkg.sv
// ----------------------------------------------------------------------------
// mcppwm_pkg
// Shared types and constants for the multi-channel pattern PWM bank.
// ----------------------------------------------------------------------------
package mcppwm_pkg;

   // Field widths
   localparam int ChanIdxWidth = 4;
   localparam int CountWidth   = 8;
   localparam int LevelsWidth  = 16;

   // Default channel count
   localparam int DefaultChannels = 16;

   // Reset values of the per-channel state
   localparam logic [CountWidth-1:0] HighLenReset = 8'd0;
   localparam logic [CountWidth-1:0] LowLenReset  = 8'd255;
   localparam logic [CountWidth-1:0] CountReset   = 8'd255;

   // Item kinds
   typedef enum logic {
      ACTION_TICK = 1'b0,
      ACTION_SET  = 1'b1
   } action_type;

   // Per-channel command for one accepted transfer
   typedef struct packed {
      logic                  set;
      logic                  tick;
      logic [CountWidth-1:0] on_count;
      logic [CountWidth-1:0] off_count;
   } chan_cmd_type;

endpackage

>>> rtl/mcppwm_channel.sv
// ----------------------------------------------------------------------------
// mcppwm_channel
// One output channel: high/low lengths, phase counter and output level.
// ----------------------------------------------------------------------------
module mcppwm_channel
   import mcppwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  chan_cmd_type cmd,
   output logic         level_in
);

   logic [CountWidth-1:0] high_len_ff, high_len_in;
   logic [CountWidth-1:0] low_len_ff, low_len_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  level_ff;

   // Next state: set overrides, tick steps the pattern
   always_comb begin
      high_len_in = high_len_ff;
      low_len_in  = low_len_ff;
      count_in    = count_ff;
      level_in    = level_ff;
      if (cmd.set) begin
         high_len_in = cmd.on_count;
         low_len_in  = cmd.off_count;
         count_in    = '0;
         level_in    = (cmd.off_count == '0);
      end else if (cmd.tick) begin
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end else if (level_ff) begin
            // locked high when the low length is zero
            if (low_len_ff == '0) begin
               count_in = high_len_ff;
            end else begin
               level_in = 1'b0;
               count_in = low_len_ff - 1'b1;
            end
         end else begin
            // locked low when the high length is zero
            if (high_len_ff == '0) begin
               count_in = low_len_ff;
            end else begin
               level_in = 1'b1;
               count_in = high_len_ff - 1'b1;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_len_ff <= HighLenReset;
         low_len_ff  <= LowLenReset;
         count_ff    <= CountReset;
         level_ff    <= 1'b0;
      end else begin
         high_len_ff <= high_len_in;
         low_len_ff  <= low_len_in;
         count_ff    <= count_in;
         level_ff    <= level_in;
      end
   end

endmodule

>>> rtl/multi_channel_pattern_pwm.sv
// ----------------------------------------------------------------------------
// multi_channel_pattern_pwm
// Bank of pattern PWM channels driven by set and tick transfers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer (req_valid high, req_stall low).
//   req_action = tick steps every channel; set loads req_on_count and
//   req_off_count into channel req_channel, clears its counter and drives
//   its level low (high when the off count is zero). Set to a channel not
//   present changes nothing.
//   rsp_* returns one transfer per item: rsp_pin_levels, bit i = channel i
//   level after the item (bits at or above CHANNELS read zero).
// Timing:
//   rsp_valid rises in the cycle after the request transfer. Throughput is
//   one item per cycle while req_stall is low: every channel updates its
//   counter in parallel in a single register stage, and the result register
//   is loaded on the same edge.
//   While rsp_stall holds a waiting result, req_stall is raised; when the
//   result drains in a cycle, a new request is taken in that same cycle.
// Reset:
//   Synchronous, active high. Channels go to high length 0, low length
//   255, counter 255, level low; the result register is emptied.
// ----------------------------------------------------------------------------
module multi_channel_pattern_pwm
   import mcppwm_pkg::*;
#(
   parameter int CHANNELS = DefaultChannels
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic [ChanIdxWidth-1:0] req_channel,
   input  logic [CountWidth-1:0]   req_on_count,
   input  logic [CountWidth-1:0]   req_off_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LevelsWidth-1:0]  rsp_pin_levels
);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LevelsWidth-1:0] pin_levels_ff;
   logic [LevelsWidth-1:0] pin_levels_in;
   logic [CHANNELS-1:0]    level_in;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   is_set;
   logic                   is_tick;

   // Handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_xfer  = rsp_valid_ff & ~rsp_stall;
   assign is_set    = req_xfer & (req_action == ACTION_SET);
   assign is_tick   = req_xfer & (req_action == ACTION_TICK);

   // Channel bank
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      chan_cmd_type cmd;
      logic         sel;
      if (c < LevelsWidth) begin : g_addr
         assign sel = (req_channel == ChanIdxWidth'(c));
      end else begin : g_noaddr
         assign sel = 1'b0;
      end
      assign cmd.set       = is_set & sel;
      assign cmd.tick      = is_tick;
      assign cmd.on_count  = req_on_count;
      assign cmd.off_count = req_off_count;

      mcppwm_channel u_channel (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .level_in (level_in[c])
      );
   end

   // Gather visible levels
   for (genvar b = 0; b < LevelsWidth; b++) begin : g_pin
      if (b < CHANNELS) begin : g_on
         assign pin_levels_in[b] = level_in[b];
      end else begin : g_off
         assign pin_levels_in[b] = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pin_levels_ff <= pin_levels_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_levels = pin_levels_ff;

`ifndef SYNTHESIS
   // Every accepted request yields a result next cycle
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("accepted request produced no result");

   // A drained result with no new request empties the output
   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !req_xfer) |=> !rsp_valid)
      else $error("result repeated after transfer");

   // Input is held off only while a result waits
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting result");
`endif

endmodule
